// ----- rtl/core/psbp_pkg.sv -----
package psbp_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned MaxRes   = 6;
  localparam int unsigned CntW     = $clog2(MaxRes + 1);

  localparam logic [7:0] CfgValueBits  = 8'd0;
  localparam logic [7:0] CfgBlockLimit = 8'd1;

  typedef enum logic [1:0] {
    KIND_MASK = 2'd0,
    KIND_REF  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [WordBits-1:0] value;
    logic                end_of_column;
  } in_beat_t;

  typedef struct packed {
    logic [WordBits-1:0] word;
    kind_e               kind;
    logic                run_last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]          index;
    logic [WordBits-1:0] data;
  } cfg_beat_t;

  typedef struct packed {
    logic [WordBits-1:0] word;
    kind_e               kind;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [CntW-1:0]   n;
  } res_list_t;

  typedef struct packed {
    logic [WordBits-1:0] acc;
    logic [5:0]          bits;
    logic [WordBits-1:0] word;
    logic                emit;
  } pack_t;

  function automatic logic [WordBits-1:0] width_mask(input logic [5:0] vb);
    logic [WordBits-1:0] m;
    m = '1;
    if (vb == 6'd8) m = 32'h0000_00FF;
    else if (vb == 6'd16) m = 32'h0000_FFFF;
    return m;
  endfunction

  function automatic logic [WordBits-1:0] low_mask(input logic [5:0] k);
    return ~({WordBits{1'b1}} << k);
  endfunction

  // priority encode: highest set bit plus one
  function automatic logic [5:0] msb_width(input logic [WordBits-1:0] d);
    logic [5:0] k;
    k = '0;
    for (int b = 0; b < WordBits; b++) begin
      if (d[b]) k = 6'(b + 1);
    end
    return k;
  endfunction

  function automatic pack_t pack_add(input logic [WordBits-1:0] acc, input logic [5:0] bits,
                                     input logic [WordBits-1:0] v, input logic [5:0] k);
    logic [2*WordBits-1:0] sum;
    logic [5:0]            nb;
    logic [5:0]            rest;
    pack_t                 r;
    sum    = ({32'd0, acc} << k) | {32'd0, v & low_mask(k)};
    nb     = bits + k;
    rest   = nb - 6'd32;
    r.word = '0;
    r.emit = 1'b0;
    r.acc  = sum[WordBits-1:0];
    r.bits = nb;
    if (nb >= 6'd32) begin
      r.emit = 1'b1;
      r.word = 32'(sum >> rest);
      r.acc  = 32'(sum & ~({(2*WordBits){1'b1}} << rest));
      r.bits = rest;
    end
    return r;
  endfunction

  // left-align the partial word, zero fill
  function automatic logic [WordBits-1:0] flush_word(input logic [WordBits-1:0] acc,
                                                     input logic [5:0] bits);
    return acc << (6'd32 - bits);
  endfunction

  function automatic res_list_t push(input res_list_t l, input logic [WordBits-1:0] w,
                                     input kind_e k);
    res_list_t r;
    r = l;
    r.ent[r.n[CntW-1:0]].word = w;
    r.ent[r.n[CntW-1:0]].kind = k;
    r.n = r.n + CntW'(1);
    return r;
  endfunction

  function automatic res_list_t close_push(input res_list_t l, input logic [WordBits-1:0] acc,
                                           input logic [5:0] bits, input logic [15:0] cnt);
    res_list_t r;
    r = l;
    if (bits != 6'd0) r = push(r, flush_word(acc, bits), KIND_DATA);
    r = push(r, {16'd0, cnt}, KIND_END);
    return r;
  endfunction

endpackage

// ----- rtl/core/psbp_stream_if.sv -----
interface psbp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/psbp_pack_core.sv -----
module psbp_pack_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  psbp_pkg::in_beat_t    beat_i,
  input  logic [5:0]            value_bits_i,
  input  logic [15:0]           block_limit_i,
  output psbp_pkg::res_list_t   list_o
);
  import psbp_pkg::*;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_HELD  = 2'd1,
    PH_OPEN  = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [WordBits-1:0] held_q, held_d;
  logic [WordBits-1:0] mask_q, mask_d;
  logic [WordBits-1:0] ref_q, ref_d;
  logic [5:0]          k_q, k_d;
  logic [WordBits-1:0] acc_q, acc_d;
  logic [5:0]          bits_q, bits_d;
  logic [15:0]         cnt_q, cnt_d;

  logic [WordBits-1:0] wm, v, first, mask_h, ref_h;
  logic [5:0]          kh;
  logic [15:0]         limit, cnt_o;
  logic                eoc, match;
  pack_t               a1, a2, ao;
  res_list_t           l;

  always_comb begin
    wm     = width_mask(value_bits_i);
    v      = beat_i.value & wm;
    eoc    = beat_i.end_of_column;
    limit  = (block_limit_i < 16'd2) ? 16'd2 : block_limit_i;
    first  = held_q & wm;
    kh     = msb_width(first ^ v);
    mask_h = ~low_mask(kh) & wm;
    ref_h  = first & mask_h;
    a1     = pack_add('0, 6'd0, first, kh);
    a2     = pack_add(a1.acc, a1.bits, v, kh);
    match  = (v & mask_q) == ref_q;
    ao     = pack_add(acc_q, bits_q, v, k_q);
    cnt_o  = cnt_q + 16'd1;

    l       = '0;
    phase_d = phase_q;
    held_d  = held_q;
    mask_d  = mask_q;
    ref_d   = ref_q;
    k_d     = k_q;
    acc_d   = acc_q;
    bits_d  = bits_q;
    cnt_d   = cnt_q;

    unique case (phase_q)
      PH_HELD: begin
        l      = push(l, mask_h, KIND_MASK);
        l      = push(l, ref_h | {26'd0, kh}, KIND_REF);
        if (a1.emit) l = push(l, a1.word, KIND_DATA);
        if (a2.emit) l = push(l, a2.word, KIND_DATA);
        mask_d = mask_h;
        ref_d  = ref_h;
        k_d    = kh;
        if (eoc || (limit <= 16'd2)) begin
          l       = close_push(l, a2.acc, a2.bits, 16'd2);
          phase_d = PH_EMPTY;
          acc_d   = '0;
          bits_d  = '0;
          cnt_d   = '0;
        end else begin
          phase_d = PH_OPEN;
          acc_d   = a2.acc;
          bits_d  = a2.bits;
          cnt_d   = 16'd2;
        end
      end
      PH_OPEN: begin
        if (match) begin
          if (ao.emit) l = push(l, ao.word, KIND_DATA);
          if (eoc || (cnt_o >= limit)) begin
            l       = close_push(l, ao.acc, ao.bits, cnt_o);
            phase_d = PH_EMPTY;
            acc_d   = '0;
            bits_d  = '0;
            cnt_d   = '0;
          end else begin
            acc_d  = ao.acc;
            bits_d = ao.bits;
            cnt_d  = cnt_o;
          end
        end else begin
          l      = close_push(l, acc_q, bits_q, cnt_q);
          acc_d  = '0;
          bits_d = '0;
          cnt_d  = '0;
          if (eoc) begin
            l       = push(l, wm, KIND_MASK);
            l       = push(l, v, KIND_REF);
            l       = push(l, 32'd1, KIND_END);
            mask_d  = wm;
            ref_d   = v;
            k_d     = '0;
            phase_d = PH_EMPTY;
          end else begin
            held_d  = v;
            phase_d = PH_HELD;
          end
        end
      end
      default: begin
        if (eoc) begin
          l       = push(l, wm, KIND_MASK);
          l       = push(l, v, KIND_REF);
          l       = push(l, 32'd1, KIND_END);
          mask_d  = wm;
          ref_d   = v;
          k_d     = '0;
          acc_d   = '0;
          bits_d  = '0;
          cnt_d   = '0;
          phase_d = PH_EMPTY;
        end else begin
          held_d  = v;
          phase_d = PH_HELD;
        end
      end
    endcase
  end

  assign list_o = l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
      held_q  <= '0;
      mask_q  <= '0;
      ref_q   <= '0;
      k_q     <= '0;
      acc_q   <= '0;
      bits_q  <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      mask_q  <= mask_d;
      ref_q   <= ref_d;
      k_q     <= k_d;
      acc_q   <= acc_d;
      bits_q  <= bits_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/psbp_result_buf.sv -----
module psbp_result_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  psbp_pkg::res_list_t list_i,
  output logic                free_o,
  psbp_stream_if.source       out_o
);
  import psbp_pkg::*;

  res_t [MaxRes-1:0] res_q;
  logic [CntW-1:0]   rem_q;
  logic              take;

  assign take         = out_o.valid && out_o.ready;
  assign free_o       = (rem_q == '0) || ((rem_q == CntW'(1)) && out_o.ready);
  assign out_o.valid  = rem_q != '0;
  assign out_o.data   = '{word: res_q[0].word, kind: res_q[0].kind,
                          run_last: rem_q == CntW'(1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= list_i.n;
    end else if (take) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  // shift line, head beat always at index 0
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= list_i.ent;
    end else if (take) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule

// ----- rtl/core/prefix_suppression_bit_packer_unit.sv -----
// Results of an item appear in the cycle after its input beat is taken. Throughput:
// one item per cycle while each yields at most one result and the output is ready;
// an item yielding n results (up to five) sends them as n beats, the result shift
// line draining one beat per cycle while the output is ready; items yielding none
// leave the buffer free. Reset: block state cleared, no block open; value_bits 32, block_limit 65535.
module prefix_suppression_bit_packer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  psbp_stream_if.sink   in_i,
  psbp_stream_if.sink   cfg_i,
  psbp_stream_if.source out_o
);
  import psbp_pkg::*;

  logic [5:0]  value_bits_q;
  logic [15:0] block_limit_q;
  logic        in_acc;
  logic        free;
  res_list_t   list;
  in_beat_t    beat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_bits_q  <= 6'd32;
      block_limit_q <= 16'hFFFF;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.data.index)
        CfgValueBits:  value_bits_q  <= cfg_i.data.data[5:0];
        CfgBlockLimit: block_limit_q <= cfg_i.data.data[15:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign beat       = '{value: in_i.data.value, end_of_column: in_i.data.end_of_column};

  psbp_pack_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .beat_i        (beat),
    .value_bits_i  (value_bits_q),
    .block_limit_i (block_limit_q),
    .list_o        (list)
  );

  psbp_result_buf u_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_acc),
    .list_i (list),
    .free_o (free),
    .out_o  (out_o)
  );

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.run_last) |-> !in_i.ready)
    else $error("input taken while results of an earlier item remain");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.run_last && !(in_i.valid && in_i.ready))
    |=> !out_o.valid)
    else $error("result beats left after the last one was taken");

  a_end_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.kind == KIND_END)) |-> (out_o.data.word != 32'd0))
    else $error("block end with zero value count");

endmodule
